### src/signed_int_to_decimal_ascii_assert.svh
// Assertion macros for the checker file of this block.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SITDA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sitda check failed");

// The consequent must hold in the cycle after the antecedent.
`define SITDA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sitda check failed");

`endif

### src/sitda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

	// Default width of the input integer.
	localparam int VALUE_WIDTH_DEF = 32;

	// Decimal digits needed at the default width.
	localparam int DIGITS_DEF = 10;

	// Binary bits that one conversion stage shifts into the digit register.
	localparam int BITS_PER_STAGE = 8;

	// Scaled approximation of log10(2), used to size the digit register.
	localparam int LOG2_NUM = 301;
	localparam int LOG2_DEN = 1000;

	// Character codes.
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Digit correction of the shift-and-add-three conversion.
	localparam logic [3:0] DIGIT_LIMIT  = 4'd5;
	localparam logic [3:0] DIGIT_ADJUST = 4'd3;

endpackage

`default_nettype wire

### src/sitda_dabble.sv
`timescale 1ns / 1ps
`default_nettype none

module sitda_dabble #(
	parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF,
	parameter int DIGITS      = sitda_pkg::DIGITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   in_neg,
	input  logic [VALUE_WIDTH-1:0] in_mag,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   out_neg,
	output logic [4*DIGITS-1:0]    out_bcd
);

	localparam int BPS = sitda_pkg::BITS_PER_STAGE;
	localparam int NS  = (VALUE_WIDTH + BPS - 1) / BPS;
	localparam int BW  = 4 * DIGITS;

	// Pipeline registers, one entry per conversion stage.
	logic                   vld_s [NS];
	logic                   neg_s [NS];
	logic [VALUE_WIDTH-1:0] bin_s [NS];
	logic [BW-1:0]          bcd_s [NS];
	logic                   rdy   [NS+1];

	// Add three to every digit of five or more before the next shift.
	function automatic logic [BW-1:0] adjust(input logic [BW-1:0] b);
		logic [BW-1:0] r;
		r = b;
		for (int d = 0; d < DIGITS; d++) begin
			if (r[4*d +: 4] >= sitda_pkg::DIGIT_LIMIT) begin
				r[4*d +: 4] = r[4*d +: 4] + sitda_pkg::DIGIT_ADJUST;
			end
		end
		return r;
	endfunction

	// A stage can take new data when it is empty or its content moves on.
	assign rdy[NS]   = out_ready;
	assign in_ready  = rdy[0];
	assign out_valid = vld_s[NS-1];
	assign out_neg   = neg_s[NS-1];
	assign out_bcd   = bcd_s[NS-1];

	generate
		for (genvar k = 0; k < NS; k++) begin : g_stage
			localparam int STEPS = (VALUE_WIDTH - k * BPS > BPS) ? BPS : (VALUE_WIDTH - k * BPS);

			logic                   src_vld;
			logic                   src_neg;
			logic [VALUE_WIDTH-1:0] src_bin;
			logic [BW-1:0]          src_bcd;
			logic [VALUE_WIDTH-1:0] nxt_bin;
			logic [BW-1:0]          nxt_bcd;

			// The first stage starts from the magnitude and an empty digit register.
			if (k == 0) begin : g_first
				assign src_vld = in_valid;
				assign src_neg = in_neg;
				assign src_bin = in_mag;
				assign src_bcd = '0;
			end else begin : g_next
				assign src_vld = vld_s[k-1];
				assign src_neg = neg_s[k-1];
				assign src_bin = bin_s[k-1];
				assign src_bcd = bcd_s[k-1];
			end

			assign rdy[k] = !vld_s[k] || rdy[k+1];

			// Shift this stage's share of binary bits into the digits.
			always_comb begin
				nxt_bcd = src_bcd;
				nxt_bin = src_bin;
				for (int j = 0; j < STEPS; j++) begin
					nxt_bcd = adjust(nxt_bcd);
					nxt_bcd = {nxt_bcd[BW-2:0], nxt_bin[VALUE_WIDTH-1]};
					nxt_bin = {nxt_bin[VALUE_WIDTH-2:0], 1'b0};
				end
			end

			// Valid bit travels with the data.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (rdy[k]) begin
					vld_s[k] <= src_vld;
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k]) begin
					neg_s[k] <= src_neg;
					bin_s[k] <= nxt_bin;
					bcd_s[k] <= nxt_bcd;
				end
			end
		end
	endgenerate

endmodule

`default_nettype wire

### src/sitda_serial.sv
`timescale 1ns / 1ps
`default_nettype none

module sitda_serial #(
	parameter int DIGITS = sitda_pkg::DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_neg,
	input  logic [4*DIGITS-1:0] in_bcd,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          ascii_char,
	output logic                last
);

	localparam int IW = $clog2(DIGITS);

	logic                busy_q;
	logic                neg_pend_q;
	logic [IW-1:0]       idx_q;
	logic [4*DIGITS-1:0] bcd_q;
	logic                out_valid_q;
	logic [7:0]          char_q;
	logic                last_q;

	logic                out_adv;
	logic                emit;
	logic                load;
	logic                final_char;
	logic [IW-1:0]       top_idx;
	logic [3:0]          digit;

	// Highest nonzero digit of the incoming number; zero keeps index zero.
	always_comb begin
		top_idx = '0;
		for (int i = 1; i < DIGITS; i++) begin
			if (in_bcd[4*i +: 4] != 4'd0) begin
				top_idx = IW'(i);
			end
		end
	end

	// The output register moves when empty or when its transaction completes.
	assign out_adv    = !out_valid_q || !out_stall;
	assign emit       = busy_q && out_adv;
	assign final_char = !neg_pend_q && (idx_q == '0);
	assign in_ready   = !busy_q || (emit && final_char);
	assign load       = in_valid && in_ready;
	assign digit      = bcd_q[{idx_q, 2'b00} +: 4];

	// Character sequencer: sign first, then digits from the top down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			neg_pend_q <= 1'b0;
			idx_q      <= '0;
		end else if (load) begin
			busy_q     <= 1'b1;
			neg_pend_q <= in_neg;
			idx_q      <= top_idx;
		end else if (emit) begin
			if (neg_pend_q) begin
				neg_pend_q <= 1'b0;
			end else if (idx_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q <= in_bcd;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_adv) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= neg_pend_q ? sitda_pkg::CHAR_MINUS : (sitda_pkg::CHAR_ZERO + {4'b0000, digit});
			last_q <= final_char;
		end
	end

	assign out_valid  = out_valid_q;
	assign ascii_char = char_q;
	assign last       = last_q;

endmodule

`default_nettype wire

### src/signed_int_to_decimal_ascii.sv
// Path: a value passes stage one, the conversion stages and the character sequencer into the output register.
// Output: one character per cycle while out_stall is low, since the output register carries one;
// an item's text has 1 to 11 characters at 32 bits.
// The conversion pipeline itself accepts an item every cycle while it has room.
// Reset: asynchronous, clears the valid bits and the character sequencer; data registers keep.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii #(
	parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    ascii_char,
	output logic                          last
);

	localparam int DIGITS = (VALUE_WIDTH * sitda_pkg::LOG2_NUM) / sitda_pkg::LOG2_DEN + 1;

	logic                   vld_s1;
	logic                   neg_s1;
	logic [VALUE_WIDTH-1:0] mag_s1;
	logic [VALUE_WIDTH-1:0] raw;
	logic                   dab_ready;
	logic                   dab_valid;
	logic                   dab_neg;
	logic [4*DIGITS-1:0]    dab_bcd;
	logic                   ser_ready;

	assign raw      = $unsigned(value);
	assign in_stall = vld_s1 && !dab_ready;

	// Stage one: sign and magnitude; the most negative value maps to itself unsigned.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			neg_s1 <= raw[VALUE_WIDTH-1];
			mag_s1 <= raw[VALUE_WIDTH-1] ? ((~raw) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;
		end
	end

	// Binary to decimal conversion pipeline.
	sitda_dabble #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.DIGITS     (DIGITS)
	) u_dabble (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s1),
		.in_ready (dab_ready),
		.in_neg   (neg_s1),
		.in_mag   (mag_s1),
		.out_valid(dab_valid),
		.out_ready(ser_ready),
		.out_neg  (dab_neg),
		.out_bcd  (dab_bcd)
	);

	// Character sequencer and output register.
	sitda_serial #(
		.DIGITS(DIGITS)
	) u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dab_valid),
		.in_ready  (ser_ready),
		.in_neg    (dab_neg),
		.in_bcd    (dab_bcd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ascii_char(ascii_char),
		.last      (last)
	);

endmodule

`default_nettype wire

### src/signed_int_to_decimal_ascii_check.sv
`timescale 1ns / 1ps
`default_nettype none
`include "signed_int_to_decimal_ascii_assert.svh"

module signed_int_to_decimal_ascii_check (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] ascii_char,
	input logic       last
);

	logic start_q;
	logic is_minus;
	logic is_digit;

	assign is_minus = (ascii_char == sitda_pkg::CHAR_MINUS);
	assign is_digit = (ascii_char >= sitda_pkg::CHAR_ZERO) && (ascii_char <= sitda_pkg::CHAR_NINE);

	// Set when the next character opens a number's text or follows its sign.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
		end else if (out_valid && !out_stall) begin
			start_q <= last || is_minus;
		end
	end

	// A stalled transaction stays offered and unchanged.
	`SITDA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`SITDA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(ascii_char) && $stable(last))
	// A sign opens a number and is never its final character; characters are digits otherwise.
	`SITDA_ASSERT_NOW(a_minus_first, out_valid && !is_digit, is_minus && start_q && !last)
	// No leading zero: a zero in leading place is the whole number.
	`SITDA_ASSERT_NOW(a_no_lead_zero, out_valid && start_q && ascii_char == sitda_pkg::CHAR_ZERO, last)

endmodule

bind signed_int_to_decimal_ascii signed_int_to_decimal_ascii_check u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.ascii_char(ascii_char),
	.last      (last)
);

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int WIDTH = sitda_pkg::VALUE_WIDTH_DEF;
	localparam int RANDOM_PER_PHASE = 90;
	localparam int DRAIN_CYCLES = 24;

	// One expected character of a number's decimal text.
	typedef struct packed {
		logic [7:0] code;
		logic       is_last;
	} text_char_t;

	// Holds the expected text of every accepted value and checks the characters as they leave.
	class decimal_text_scoreboard;
		text_char_t expected_text[$];
		int errors;
		int values_seen;
		int chars_seen;

		function new();
			errors = 0;
			values_seen = 0;
			chars_seen = 0;
		endfunction

		// Forms the decimal text of an accepted value and queues it.
		function void note_value(logic signed [WIDTH-1:0] v);
			logic [WIDTH:0] magnitude;
			logic [7:0] digits[$];
			bit negative;
			negative = v[WIDTH-1];
			// One bit wider, so the most negative value has an exact magnitude.
			magnitude = negative ? ((WIDTH+1)'(0) - {v[WIDTH-1], v}) : {1'b0, v};
			do begin
				digits.push_front(sitda_pkg::CHAR_ZERO + 8'(magnitude % 10));
				magnitude = magnitude / 10;
			end while (magnitude != 0);
			if (negative) begin
				expected_text.push_back('{code: sitda_pkg::CHAR_MINUS, is_last: 1'b0});
			end
			foreach (digits[i]) begin
				expected_text.push_back('{code: digits[i], is_last: (i == digits.size() - 1)});
			end
			values_seen++;
		endfunction

		// Compares one outgoing character with the oldest expected one.
		function void check_char(logic [7:0] code, logic is_last);
			text_char_t want;
			chars_seen++;
			if (expected_text.size() == 0) begin
				$display("%0t: unexpected character 0x%02h last=%0b", $time, code, is_last);
				errors++;
				return;
			end
			want = expected_text.pop_front();
			if (code !== want.code) begin
				$display("%0t: ascii_char expected 0x%02h actual 0x%02h", $time, want.code, code);
				errors++;
			end
			if (is_last !== want.is_last) begin
				$display("%0t: last expected %0b actual %0b", $time, want.is_last, is_last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_text.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [WIDTH-1:0] value;
	logic out_valid;
	logic out_stall;
	logic [7:0] ascii_char;
	logic last;

	int sender_idle_pct;
	int receiver_stall_pct;
	decimal_text_scoreboard text_board;

	signed_int_to_decimal_ascii #(
		.VALUE_WIDTH(WIDTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ascii_char(ascii_char),
		.last(last)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver stall, redrawn every cycle.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// Transaction monitors on both channels.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			text_board.note_value(value);
		end
		if (arst_n && out_valid && !out_stall) begin
			text_board.check_char(ascii_char, last);
		end
	end

	// Drives one value, with random idle cycles ahead of it; called and left at a falling edge.
	task automatic send_value(input logic signed [WIDTH-1:0] v);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Random value whose digit count is spread evenly, with some full-range words.
	function automatic logic signed [WIDTH-1:0] random_value();
		longint lo;
		longint hi;
		longint magnitude;
		int digit_count;
		bit negative;
		if ($urandom_range(4) == 0) begin
			return $urandom;
		end
		digit_count = $urandom_range(10, 1);
		negative = ($urandom_range(1) == 1);
		lo = (digit_count == 1) ? 64'sd0 : longint'(10) ** (digit_count - 1);
		hi = longint'(10) ** digit_count - 1;
		if (hi > 64'sd2147483647) begin
			hi = negative ? 64'sd2147483648 : 64'sd2147483647;
		end
		magnitude = lo + longint'($urandom_range(32'(hi - lo)));
		return negative ? WIDTH'(-magnitude) : WIDTH'(magnitude);
	endfunction

	// Sets the idling of both sides for one phase.
	task automatic set_idling(input int idle_pct, input int stall_pct);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
	endtask

	// Stimulus and end of run.
	initial begin
		logic signed [WIDTH-1:0] directed_values[$];
		text_board = new();
		in_valid = 1'b0;
		value = '0;
		out_stall = 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Zero, single digits, digit-count boundaries, both extremes and alternating bit patterns.
		directed_values = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
			32'sd99, 32'sd100, 32'sd999999999, -32'sd999999999, 32'sd1000000000,
			-32'sd1000000000, 32'sd1234567890, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001,
			32'sh55555555, 32'shAAAAAAAA, 32'shFFFFFFFE};
		foreach (directed_values[i]) begin
			send_value(directed_values[i]);
		end

		// Random phases: no idling, idle sender, stalling receiver, then both.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					set_idling(0, 0);
				end
				1: begin
					set_idling(61, 0);
				end
				2: begin
					set_idling(0, 61);
				end
				default: begin
					set_idling(27, 27);
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				send_value(random_value());
			end
		end
		in_valid <= 1'b0;

		// Drain everything that is expected, then watch for stray characters.
		while (text_board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d values into %0d characters, covering zero, both extremes,",
			text_board.values_seen, text_board.chars_seen);
		$display("every digit count and four sender and receiver idling mixes.");
		if (text_board.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#1000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
